FILE: sv/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg: shared types and constants of the bass-envelope beat detector
// Fixed-point coefficients, widths, register codes, sequencer types and the
// saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package abd_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W      = 10;
  localparam int POT_W         = 10;
  localparam int DC_W          = 10;
  localparam int PERIOD_W      = 16;
  localparam int LEVEL_W       = 32;
  localparam int CENTER_W      = SAMPLE_W + 1;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  // Default number of fraction bits of the datapath levels
  localparam int FRACTION_BITS = 16;

  // MAC geometry: operand fed one 8-bit digit per cycle
  localparam int COEF_FRAC = 28;
  localparam int COEF_W    = 32;
  localparam int ACC_W     = 64;
  localparam int DIGIT_W   = 8;
  localparam int OP_W      = 40;
  localparam int NDIG      = OP_W / DIGIT_W;
  localparam int DCNT_W    = $clog2(NDIG);
  localparam int TERM_W    = 2;

  // Configuration register codes and reset values
  localparam logic [CFG_INDEX_W-1:0] REG_DC_OFFSET         = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_DECIMATION_PERIOD = CFG_INDEX_W'(1);
  localparam logic [DC_W-1:0]        DC_OFFSET_RESET       = DC_W'(503);
  localparam logic [PERIOD_W-1:0]    PERIOD_RESET          = PERIOD_W'(200);

  // Q28 coefficients, rounded to nearest from their decimal values
  localparam longint CONE        = 64'sd1 <<< COEF_FRAC;
  localparam longint DEC_SCALE   = 64'sd10000000000;
  localparam longint DEC_HALF    = 64'sd5000000000;
  localparam longint Q_BASS_A0   = -((64'sd7960060012 * CONE + DEC_HALF) / DEC_SCALE);
  localparam longint Q_BASS_A1   = (64'sd17903124146 * CONE + DEC_HALF) / DEC_SCALE;
  localparam longint Q_ENV_A0    = (64'sd9875119299 * CONE + DEC_HALF) / DEC_SCALE;
  localparam longint Q_BEAT_A0   = -((64'sd7169861741 * CONE + DEC_HALF) / DEC_SCALE);
  localparam longint Q_BEAT_A1   = (64'sd14453653501 * CONE + DEC_HALF) / DEC_SCALE;
  localparam longint Q_GAIN_BASS = (64'sd10 * CONE + 64'sd45) / 64'sd91;
  localparam longint Q_GAIN_ENV  = (CONE + 64'sd80) / 64'sd160;
  localparam longint Q_GAIN_BEAT = (64'sd1000 * CONE + 64'sd3507) / 64'sd7015;

  localparam logic signed [COEF_W-1:0] COEF_ONE       = COEF_W'(CONE);
  localparam logic signed [COEF_W-1:0] COEF_BASS_A0   = COEF_W'(Q_BASS_A0);
  localparam logic signed [COEF_W-1:0] COEF_BASS_A1   = COEF_W'(Q_BASS_A1);
  localparam logic signed [COEF_W-1:0] COEF_ENV_A0    = COEF_W'(Q_ENV_A0);
  localparam logic signed [COEF_W-1:0] COEF_BEAT_A0   = COEF_W'(Q_BEAT_A0);
  localparam logic signed [COEF_W-1:0] COEF_BEAT_A1   = COEF_W'(Q_BEAT_A1);
  localparam logic signed [COEF_W-1:0] COEF_GAIN_BASS = COEF_W'(Q_GAIN_BASS);
  localparam logic signed [COEF_W-1:0] COEF_GAIN_ENV  = COEF_W'(Q_GAIN_ENV);
  localparam logic signed [COEF_W-1:0] COEF_GAIN_BEAT = COEF_W'(Q_GAIN_BEAT);
  localparam logic signed [COEF_W-1:0] COEF_THRESH    = COEF_W'(50);

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_MAC,
    S_DONE
  } state_t;

  // Filter passes, in processing order
  typedef enum logic [2:0] {
    P_GAIN_BASS,
    P_BASS,
    P_GAIN_ENV,
    P_ENV,
    P_GAIN_BEAT,
    P_BEAT,
    P_THRESH
  } pass_t;

  // MAC control from the sequencer
  typedef struct packed {
    logic clr;
    logic load;
  } mac_ctl_t;

  // Clamp a wide value to the signed 32-bit range
  function automatic logic signed [LEVEL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'({1'b0, {(LEVEL_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      return {1'b0, {(LEVEL_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(LEVEL_W-1){1'b0}}};
    end
    return v[LEVEL_W-1:0];
  endfunction

  // Rectifier: most negative value maps to most positive
  function automatic logic signed [LEVEL_W-1:0] abs_sat(input logic signed [LEVEL_W-1:0] v);
    if (v == {1'b1, {(LEVEL_W-1){1'b0}}}) begin
      return {1'b0, {(LEVEL_W-1){1'b1}}};
    end else if (v < 0) begin
      return -v;
    end
    return v;
  endfunction

endpackage

FILE: sv/abd_if.sv
// ----------------------------------------------------------------------------
// abd_if: stream interfaces of the beat detector
// Sample request channel and beat result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface abd_in_if;
  logic                          valid;
  logic                          ready;
  logic [abd_pkg::SAMPLE_W-1:0]  audio_sample;
  logic [abd_pkg::POT_W-1:0]     threshold_pot;

  modport source (output valid, output audio_sample, output threshold_pot, input ready);
  modport sink   (input valid, input audio_sample, input threshold_pot, output ready);
endinterface

interface abd_out_if;
  logic                                valid;
  logic                                ready;
  logic                                beat_detected;
  logic signed [abd_pkg::LEVEL_W-1:0]  beat_level;

  modport source (output valid, output beat_detected, output beat_level, input ready);
  modport sink   (input valid, input beat_detected, input beat_level, output ready);
endinterface

FILE: sv/audio_beat_detector.sv
// ----------------------------------------------------------------------------
// audio_beat_detector: bass-envelope beat detector
// Every sample runs the gain, bass and envelope passes; a sample that reaches
// the decimation period also runs the beat passes and posts a result.
// A new sample is accepted only while idle, after the last one is through,
// as all products share the single digit-serial MAC (7 or 12 products).
// Reset clears all filter history, the sample counter and the result slot,
// and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module audio_beat_detector #(
  parameter int FRACTION_BITS = abd_pkg::FRACTION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  abd_in_if.sink                               in_chan,
  abd_out_if.source                            out_chan,
  input  logic                                 cfg_we,
  input  logic [abd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [abd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int LW = abd_pkg::LEVEL_W;
  localparam int AW = abd_pkg::ACC_W;
  localparam int OW = abd_pkg::OP_W;
  localparam int TW = abd_pkg::TERM_W;
  localparam logic signed [AW-1:0] HALF_IN  =
    AW'(64'sd1 <<< (abd_pkg::COEF_FRAC - FRACTION_BITS - 1));
  localparam logic signed [AW-1:0] HALF_OUT = AW'(64'sd1 <<< (abd_pkg::COEF_FRAC - 1));

  abd_pkg::state_t   state_r, state_nxt;
  abd_pkg::pass_t    pass_r, pass_nxt;
  logic [TW-1:0]     term_r, term_nxt;
  logic [TW-1:0]     term_sel;
  logic [TW-1:0]     term_last;
  abd_pkg::mac_ctl_t mac_ctl;
  logic              mac_last;
  logic signed [AW-1:0] mac_acc;
  logic signed [AW-1:0] mac_init;
  logic signed [OW-1:0] mac_op;
  logic signed [abd_pkg::COEF_W-1:0] mac_coef;

  // configuration
  logic [abd_pkg::DC_W-1:0]     dc_offset_r;
  logic [abd_pkg::PERIOD_W-1:0] period_r;

  // request payload
  logic signed [abd_pkg::CENTER_W-1:0] centered_r;
  logic [abd_pkg::POT_W-1:0]           pot_r;

  // filter state and scratch value
  logic signed [LW-1:0] tmp_r;
  logic signed [LW-1:0] bass_in0_r, bass_in1_r, bass_out0_r, bass_out1_r;
  logic signed [LW-1:0] env_in_r, env_out_r;
  logic signed [LW-1:0] beat_in0_r, beat_in1_r, beat_out0_r, beat_out1_r;
  logic [abd_pkg::PERIOD_W-1:0] count_r;

  // result slot
  logic                 out_valid_r;
  logic                 out_beat_r;
  logic signed [LW-1:0] out_level_r;

  logic                 in_accept;
  logic                 out_free;
  logic                 hit;
  logic signed [AW-1:0] res_sh;
  logic signed [LW-1:0] res;

  assign in_chan.ready      = (state_r == abd_pkg::S_IDLE);
  assign in_accept          = in_chan.valid && in_chan.ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.beat_detected = out_beat_r;
  assign out_chan.beat_level    = out_level_r;
  assign out_free           = !out_valid_r || out_chan.ready;
  assign hit                = (count_r == period_r);

  // rounded and clamped pass result
  assign res_sh = (pass_r == abd_pkg::P_GAIN_BASS) ?
                  (mac_acc >>> (abd_pkg::COEF_FRAC - FRACTION_BITS)) :
                  (mac_acc >>> abd_pkg::COEF_FRAC);
  assign res    = abd_pkg::sat32(res_sh);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_offset_r <= abd_pkg::DC_OFFSET_RESET;
      period_r    <= abd_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        abd_pkg::REG_DC_OFFSET:         dc_offset_r <= cfg_wdata[abd_pkg::DC_W-1:0];
        abd_pkg::REG_DECIMATION_PERIOD: period_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= abd_pkg::S_IDLE;
      pass_r  <= abd_pkg::P_GAIN_BASS;
      term_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      term_r  <= term_nxt;
    end
  end

  // number of products per pass, less one
  always_comb begin
    case (pass_r)
      abd_pkg::P_BASS, abd_pkg::P_BEAT: term_last = TW'(2);
      abd_pkg::P_ENV:                   term_last = TW'(1);
      default:                          term_last = TW'(0);
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    term_nxt  = term_r;
    mac_ctl   = '0;
    case (state_r)
      abd_pkg::S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = abd_pkg::S_INIT;
          pass_nxt  = abd_pkg::P_GAIN_BASS;
        end
      end
      abd_pkg::S_INIT: begin
        mac_ctl.clr  = 1'b1;
        mac_ctl.load = 1'b1;
        term_nxt     = '0;
        state_nxt    = abd_pkg::S_MAC;
      end
      abd_pkg::S_MAC: begin
        if (mac_last) begin
          if (term_r != term_last) begin
            mac_ctl.load = 1'b1;
            term_nxt     = term_r + TW'(1);
          end else begin
            state_nxt = abd_pkg::S_DONE;
          end
        end
      end
      abd_pkg::S_DONE: begin
        case (pass_r)
          abd_pkg::P_GAIN_BASS: begin
            pass_nxt = abd_pkg::P_BASS;     state_nxt = abd_pkg::S_INIT;
          end
          abd_pkg::P_BASS: begin
            pass_nxt = abd_pkg::P_GAIN_ENV; state_nxt = abd_pkg::S_INIT;
          end
          abd_pkg::P_GAIN_ENV: begin
            pass_nxt = abd_pkg::P_ENV;      state_nxt = abd_pkg::S_INIT;
          end
          abd_pkg::P_ENV: begin
            if (hit) begin
              pass_nxt  = abd_pkg::P_GAIN_BEAT;
              state_nxt = abd_pkg::S_INIT;
            end else begin
              state_nxt = abd_pkg::S_IDLE;
            end
          end
          abd_pkg::P_GAIN_BEAT: begin
            pass_nxt = abd_pkg::P_BEAT;     state_nxt = abd_pkg::S_INIT;
          end
          abd_pkg::P_BEAT: begin
            pass_nxt = abd_pkg::P_THRESH;   state_nxt = abd_pkg::S_INIT;
          end
          abd_pkg::P_THRESH: begin
            // hold until the result slot is free
            if (out_free) begin
              state_nxt = abd_pkg::S_IDLE;
            end
          end
          default: state_nxt = abd_pkg::S_IDLE;
        endcase
      end
      default: state_nxt = abd_pkg::S_IDLE;
    endcase
  end

  // product selection for the pass and term being loaded
  assign term_sel = (state_r == abd_pkg::S_INIT) ? '0 : (term_r + TW'(1));

  always_comb begin
    mac_init = HALF_OUT;
    mac_op   = '0;
    mac_coef = abd_pkg::COEF_ONE;
    case (pass_r)
      abd_pkg::P_GAIN_BASS: begin
        mac_init = HALF_IN;
        mac_op   = OW'(centered_r);
        mac_coef = abd_pkg::COEF_GAIN_BASS;
      end
      abd_pkg::P_BASS: begin
        case (term_sel)
          TW'(0): begin
            mac_op = OW'(tmp_r) - OW'(bass_in0_r); mac_coef = abd_pkg::COEF_ONE;
          end
          TW'(1): begin
            mac_op = OW'(bass_out0_r); mac_coef = abd_pkg::COEF_BASS_A0;
          end
          default: begin
            mac_op = OW'(bass_out1_r); mac_coef = abd_pkg::COEF_BASS_A1;
          end
        endcase
      end
      abd_pkg::P_GAIN_ENV: begin
        mac_op   = OW'(abd_pkg::abs_sat(bass_out1_r));
        mac_coef = abd_pkg::COEF_GAIN_ENV;
      end
      abd_pkg::P_ENV: begin
        case (term_sel)
          TW'(0): begin
            mac_op = OW'(env_in_r) + OW'(tmp_r); mac_coef = abd_pkg::COEF_ONE;
          end
          default: begin
            mac_op = OW'(env_out_r); mac_coef = abd_pkg::COEF_ENV_A0;
          end
        endcase
      end
      abd_pkg::P_GAIN_BEAT: begin
        mac_op   = OW'(env_out_r);
        mac_coef = abd_pkg::COEF_GAIN_BEAT;
      end
      abd_pkg::P_BEAT: begin
        case (term_sel)
          TW'(0): begin
            mac_op = OW'(tmp_r) - OW'(beat_in0_r); mac_coef = abd_pkg::COEF_ONE;
          end
          TW'(1): begin
            mac_op = OW'(beat_out0_r); mac_coef = abd_pkg::COEF_BEAT_A0;
          end
          default: begin
            mac_op = OW'(beat_out1_r); mac_coef = abd_pkg::COEF_BEAT_A1;
          end
        endcase
      end
      abd_pkg::P_THRESH: begin
        // 50 * level - pot * 2^F, positive means a beat
        mac_init = -(signed'(AW'(pot_r)) <<< FRACTION_BITS);
        mac_op   = OW'(beat_out1_r);
        mac_coef = abd_pkg::COEF_THRESH;
      end
      default: ;
    endcase
  end

  abd_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .init    (mac_init),
    .operand (mac_op),
    .coef    (mac_coef),
    .last    (mac_last),
    .acc     (mac_acc)
  );

  // request capture and scratch value from the gain passes
  always_ff @(posedge clk) begin
    if (in_accept) begin
      centered_r <= signed'({1'b0, in_chan.audio_sample}) - signed'({1'b0, dc_offset_r});
      pot_r      <= in_chan.threshold_pot;
    end
    if (state_r == abd_pkg::S_DONE) begin
      case (pass_r)
        abd_pkg::P_GAIN_BASS, abd_pkg::P_GAIN_ENV, abd_pkg::P_GAIN_BEAT: tmp_r <= res;
        default: ;
      endcase
    end
  end

  // filter history and sample counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bass_in0_r  <= '0;
      bass_in1_r  <= '0;
      bass_out0_r <= '0;
      bass_out1_r <= '0;
      env_in_r    <= '0;
      env_out_r   <= '0;
      beat_in0_r  <= '0;
      beat_in1_r  <= '0;
      beat_out0_r <= '0;
      beat_out1_r <= '0;
      count_r     <= '0;
    end else if (state_r == abd_pkg::S_DONE) begin
      case (pass_r)
        abd_pkg::P_BASS: begin
          bass_in0_r  <= bass_in1_r;
          bass_in1_r  <= tmp_r;
          bass_out0_r <= bass_out1_r;
          bass_out1_r <= res;
        end
        abd_pkg::P_ENV: begin
          env_in_r  <= tmp_r;
          env_out_r <= res;
          count_r   <= hit ? abd_pkg::PERIOD_W'(1) : (count_r + abd_pkg::PERIOD_W'(1));
        end
        abd_pkg::P_BEAT: begin
          beat_in0_r  <= beat_in1_r;
          beat_in1_r  <= tmp_r;
          beat_out0_r <= beat_out1_r;
          beat_out1_r <= res;
        end
        default: ;
      endcase
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == abd_pkg::S_DONE && pass_r == abd_pkg::P_THRESH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == abd_pkg::S_DONE && pass_r == abd_pkg::P_THRESH && out_free) begin
      out_beat_r  <= (mac_acc > 0);
      out_level_r <= beat_out1_r;
    end
  end

endmodule

FILE: sv/abd_mac.sv
// ----------------------------------------------------------------------------
// abd_mac: digit-serial multiply-accumulate unit
// The operand shifts out one 8-bit digit per cycle; each digit times the
// coefficient is added into a 64-bit accumulator at the digit's weight.
// ----------------------------------------------------------------------------
module abd_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  abd_pkg::mac_ctl_t                   ctl,
  input  logic signed [abd_pkg::ACC_W-1:0]    init,
  input  logic signed [abd_pkg::OP_W-1:0]     operand,
  input  logic signed [abd_pkg::COEF_W-1:0]   coef,
  output logic                                last,
  output logic signed [abd_pkg::ACC_W-1:0]    acc
);

  logic [abd_pkg::OP_W-1:0]                        op_sr_r;
  logic signed [abd_pkg::COEF_W-1:0]               coef_r;
  logic signed [abd_pkg::ACC_W-1:0]                acc_r;
  logic signed [abd_pkg::ACC_W-1:0]                acc_nxt;
  logic [abd_pkg::DCNT_W-1:0]                      dig_cnt_r;
  logic                                            busy_r;
  logic signed [abd_pkg::DIGIT_W:0]                digit;
  logic signed [abd_pkg::COEF_W+abd_pkg::DIGIT_W:0] pp;
  logic signed [abd_pkg::ACC_W-1:0]                pp_sh;

  // top digit carries the operand sign, lower digits are unsigned
  assign last  = busy_r && (dig_cnt_r == abd_pkg::DCNT_W'(abd_pkg::NDIG - 1));
  assign digit = last ? {op_sr_r[abd_pkg::DIGIT_W-1], op_sr_r[abd_pkg::DIGIT_W-1:0]}
                      : {1'b0, op_sr_r[abd_pkg::DIGIT_W-1:0]};
  assign pp      = coef_r * digit;
  assign pp_sh   = abd_pkg::ACC_W'(pp) <<< (abd_pkg::DIGIT_W * dig_cnt_r);
  assign acc_nxt = acc_r + pp_sh;
  assign acc     = acc_r;

  // digit counter and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      dig_cnt_r <= '0;
    end else if (ctl.load) begin
      busy_r    <= 1'b1;
      dig_cnt_r <= '0;
    end else if (busy_r) begin
      dig_cnt_r <= dig_cnt_r + abd_pkg::DCNT_W'(1);
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // operand shift register, coefficient and accumulator
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_sr_r <= operand;
      coef_r  <= coef;
    end else if (busy_r) begin
      op_sr_r <= op_sr_r >> abd_pkg::DIGIT_W;
    end
    if (ctl.clr) begin
      acc_r <= init;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

endmodule
